// ----- hdl/afc_pkg.sv -----
package afc_pkg;

    localparam int HISTORY_DEPTH_DEF = 16;
    localparam int SAMPLE_W          = 8;
    localparam int POS_W             = 16;
    localparam int PULSE_W           = 16;
    localparam int VCOUNT_W          = 8;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int SUM_W             = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULL_STEP     = 3'd0,
        CFG_MICROSTEP     = 3'd1,
        CFG_STARTUP_LIMIT = 3'd2,
        CFG_LONG_LIMIT    = 3'd3,
        CFG_SLOW_NEG      = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [3:0]  full_step_threshold;
        logic [8:0]  microstep_resolution;
        logic [15:0] startup_pulse_limit;
        logic [15:0] long_filter_pulse_limit;
        logic [6:0]  slow_negative_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        full_step_threshold:     4'd1,
        microstep_resolution:    9'd1,
        startup_pulse_limit:     16'd256,
        long_filter_pulse_limit: 16'd800,
        slow_negative_threshold: 7'd3
    };

    typedef struct packed {
        logic [PULSE_W-1:0]  pulse_count;
        logic [VCOUNT_W-1:0] valid_history_count;
        logic [POS_W-1:0]    motor_position;
        logic [POS_W-1:0]    motor_target;
    } t_ctx;

    typedef struct packed {
        logic [POS_W-1:0]           new_target;
        logic                       set_target;
        logic signed [SAMPLE_W-1:0] filtered_error;
        logic                       fast_done;
    } t_res;

endpackage

// ----- hdl/afc_in_if.sv -----
interface afc_in_if;
    import afc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] error_sample;
    logic [PULSE_W-1:0]         pulse_count;
    logic [VCOUNT_W-1:0]        valid_history_count;
    logic [POS_W-1:0]           motor_position;
    logic [POS_W-1:0]           motor_target;
    logic                       restart_fast;

    modport source (
        output valid, error_sample, pulse_count, valid_history_count,
               motor_position, motor_target, restart_fast,
        input  ready
    );

    modport sink (
        input  valid, error_sample, pulse_count, valid_history_count,
               motor_position, motor_target, restart_fast,
        output ready
    );

endinterface

// ----- hdl/afc_out_if.sv -----
interface afc_out_if;
    import afc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [POS_W-1:0]           new_target;
    logic                       set_target;
    logic signed [SAMPLE_W-1:0] filtered_error;
    logic                       fast_done;

    modport source (
        output valid, new_target, set_target, filtered_error, fast_done,
        input  ready
    );

    modport sink (
        input  valid, new_target, set_target, filtered_error, fast_done,
        output ready
    );

endinterface

// ----- hdl/afc_hist.sv -----
module afc_hist #(
    parameter int HISTORY_DEPTH = afc_pkg::HISTORY_DEPTH_DEF,
    parameter int AW            = $clog2(HISTORY_DEPTH)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [AW-1:0]                       i_wr_addr,
    input  logic signed [afc_pkg::SAMPLE_W-1:0] i_wr_data,
    input  logic                                i_rd_en,
    input  logic [AW-1:0]                       i_rd_addr,
    output logic signed [afc_pkg::SAMPLE_W-1:0] o_rd_data
);
    import afc_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [HISTORY_DEPTH];
    logic [HISTORY_DEPTH-1:0]   r_vld;
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic                       r_rvld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= r_mem[i_rd_addr];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rvld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rvld ? r_rdata : '0;

endmodule

// ----- hdl/afc_decide.sv -----
module afc_decide (
    input  afc_pkg::t_cfg                       i_cfg,
    input  afc_pkg::t_ctx                       i_ctx,
    input  logic signed [afc_pkg::SAMPLE_W-1:0] i_filt,
    input  logic                                i_fast_done,
    output afc_pkg::t_res                       o_res
);
    import afc_pkg::*;

    logic              fd1;
    logic signed [10:0] f, t1, t3, t6, t9, t10, snt, res_s;
    logic signed [3:0]  steps;
    logic signed [14:0] mv;
    logic signed [17:0] pos_s, sum;
    logic [POS_W-1:0]   fast_tgt;

    always_comb begin
        f     = 11'(i_filt);
        t1    = 11'(i_cfg.full_step_threshold);
        t3    = (t1 <<< 1) + t1;
        t6    = t3 <<< 1;
        t9    = t6 + t3;
        t10   = (t1 <<< 3) + (t1 <<< 1);
        snt   = 11'(i_cfg.slow_negative_threshold);
        res_s = 11'(i_cfg.microstep_resolution);
        fd1   = i_fast_done | (i_ctx.pulse_count >= i_cfg.startup_pulse_limit);

        priority if (f > t9)   steps = 4'sd4;
        else if (f > t6)       steps = 4'sd3;
        else if (f > t3)       steps = 4'sd2;
        else if (f > t1)       steps = 4'sd1;
        else if (f > -t1)      steps = 4'sd0;
        else if (f > -t3)      steps = -4'sd1;
        else if (f > -t6)      steps = -4'sd2;
        else if (f > -t9)      steps = -4'sd3;
        else                   steps = -4'sd4;

        mv    = steps * res_s;
        pos_s = signed'({2'b00, i_ctx.motor_position});
        sum   = pos_s + 18'(mv);

        priority if (sum > 18'sd65535) fast_tgt = {POS_W{1'b1}};
        else if (sum < 18'sd0)         fast_tgt = '0;
        else                           fast_tgt = sum[POS_W-1:0];

        o_res.filtered_error = i_filt;
        o_res.new_target     = '0;
        o_res.set_target     = 1'b0;
        o_res.fast_done      = fd1;

        if (!fd1) begin
            o_res.new_target = fast_tgt;
            o_res.set_target = 1'b1;
            if (steps == 4'sd0 && i_ctx.pulse_count >= 16'd4) begin
                o_res.fast_done = 1'b1;
            end
        end else if (i_ctx.motor_position == i_ctx.motor_target) begin
            if (f > t10) begin
                if (i_ctx.motor_position != {POS_W{1'b1}}) begin
                    o_res.new_target = i_ctx.motor_position + 16'd1;
                    o_res.set_target = 1'b1;
                end
            end else if (f < -snt) begin
                if (i_ctx.motor_position != '0) begin
                    o_res.new_target = i_ctx.motor_position - 16'd1;
                    o_res.set_target = 1'b1;
                end
            end
        end
    end

endmodule

// ----- hdl/tuner_afc_step_controller.sv -----
// Channel  Dir  Handshake      Payload
// i_in     in   valid / ready  error_sample, pulse_count, valid_history_count,
//                              motor_position, motor_target, restart_fast
// o_out    out  valid / ready  new_target, set_target, filtered_error, fast_done
// i_cfg_*  in   write enable   register index, write data
//
// One item at a time: each beat reads n history samples before its result, n being
// 2, 4 or 8, one read a cycle from the read port of the dual-port history memory.
// A new beat is accepted as soon as the sequencer is idle, even while a result waits.
// A result waiting on o_out.ready holds the sequencer before it loads the next one.
// Synchronous active-low reset empties the history, clears write pointer and latch.
module tuner_afc_step_controller #(
    parameter int HISTORY_DEPTH = afc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    afc_in_if.sink                                i_in,
    afc_out_if.source                             o_out,
    input  logic                                  i_cfg_we,
    input  logic [afc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [afc_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import afc_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} t_state;

    t_state              r_state;
    t_cfg                r_cfg;
    t_ctx                r_ctx;
    logic [AW-1:0]       r_wp;
    logic [AW-1:0]       r_base;
    logic                r_fast_done;
    logic                r_fd0;
    logic [3:0]          r_n;
    logic [3:0]          r_issue;
    logic                r_pend;
    logic                r_zero;
    logic signed [SUM_W-1:0] r_sum;
    logic                r_out_valid;
    t_res                r_out;

    logic                in_acc;
    logic                fd0;
    logic [3:0]          n_n;
    logic                n_zero;
    logic                rd_en;
    logic [AW:0]         off, base_x, raddr_x;
    logic [AW-1:0]       raddr;
    logic signed [SAMPLE_W-1:0] rdata;
    logic signed [SUM_W-1:0]    avg;
    logic signed [SAMPLE_W-1:0] filt;
    t_res                res;
    logic                load_out;

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid & i_in.ready;

    always_comb begin
        fd0 = i_in.restart_fast ? 1'b0 : r_fast_done;
        if (!fd0) begin
            n_n    = 4'd2;
            n_zero = (i_in.pulse_count < 16'd2);
        end else begin
            n_n    = (i_in.pulse_count < r_cfg.long_filter_pulse_limit) ? 4'd4 : 4'd8;
            n_zero = (i_in.pulse_count < 16'(n_n)) ||
                     (i_in.valid_history_count < 8'(n_n));
        end
    end

    // walk back from the newest sample, wrapping at the ring depth
    always_comb begin
        rd_en  = (r_state == S_READ) && (r_issue < r_n);
        off    = (AW+1)'(r_issue[2:0]);
        base_x = {1'b0, r_base};
        if (base_x >= off) begin
            raddr_x = base_x - off;
        end else begin
            raddr_x = base_x + (AW+1)'(HISTORY_DEPTH) - off;
        end
        raddr = raddr_x[AW-1:0];
    end

    afc_hist #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .AW            (AW)
    ) u_hist (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc),
        .i_wr_addr (r_wp),
        .i_wr_data (i_in.error_sample),
        .i_rd_en   (rd_en),
        .i_rd_addr (raddr),
        .o_rd_data (rdata)
    );

    always_comb begin
        unique case (r_n)
            4'd2:    avg = r_sum >>> 1;
            4'd4:    avg = r_sum >>> 2;
            default: avg = r_sum >>> 3;
        endcase
        filt = r_zero ? '0 : avg[SAMPLE_W-1:0];
    end

    afc_decide u_decide (
        .i_cfg       (r_cfg),
        .i_ctx       (r_ctx),
        .i_filt      (filt),
        .i_fast_done (r_fd0),
        .o_res       (res)
    );

    assign load_out = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FULL_STEP:     r_cfg.full_step_threshold     <= i_cfg_data[3:0];
                CFG_MICROSTEP:     r_cfg.microstep_resolution    <= i_cfg_data[8:0];
                CFG_STARTUP_LIMIT: r_cfg.startup_pulse_limit     <= i_cfg_data;
                CFG_LONG_LIMIT:    r_cfg.long_filter_pulse_limit <= i_cfg_data;
                CFG_SLOW_NEG:      r_cfg.slow_negative_threshold <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fast_done <= 1'b0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_issue     <= '0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ctx.pulse_count         <= i_in.pulse_count;
                        r_ctx.valid_history_count <= i_in.valid_history_count;
                        r_ctx.motor_position      <= i_in.motor_position;
                        r_ctx.motor_target        <= i_in.motor_target;
                        r_fd0   <= fd0;
                        r_n     <= n_n;
                        r_zero  <= n_zero;
                        r_base  <= r_wp;
                        r_wp    <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                        r_issue <= '0;
                        r_pend  <= 1'b0;
                        r_sum   <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_pend <= rd_en;
                    if (rd_en) begin
                        r_issue <= r_issue + 4'd1;
                    end
                    if (r_pend) begin
                        r_sum <= r_sum + SUM_W'(rdata);
                    end
                    if (!rd_en && !r_pend) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_out       <= res;
                        r_fast_done <= res.fast_done;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.new_target     = r_out.new_target;
    assign o_out.set_target     = r_out.set_target;
    assign o_out.filtered_error = r_out.filtered_error;
    assign o_out.fast_done      = r_out.fast_done;

    a_accept_starts_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_READ))
        else $error("accepted beat did not start the history walk");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_issue <= r_n))
        else $error("history read count overran the filter length");

    a_fast_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.fast_done) |-> o_out.set_target)
        else $error("fast mode result without a target");

    a_idle_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.set_target) |-> (o_out.new_target == '0))
        else $error("target given without set flag");

endmodule

// ----- verif/afc_step_checker.sv -----
`timescale 1ns / 1ps

import afc_pkg::*;

module afc_step_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    afc_in_if                     i_in_bus,
    afc_out_if                    i_out_bus,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_results,
    output int                    o_moves
);

    t_cfg                       regs;
    logic signed [SAMPLE_W-1:0] err_ring [HISTORY_DEPTH_DEF];
    logic [3:0]                 ring_wr;
    logic                       fast_latch;
    t_res                       target_q [$];

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    function automatic int ring_average(input int count, input int shift);
        int sum;
        int loc;
        sum = 0;
        loc = int'(ring_wr);
        for (int k = 0; k < count; k++) begin
            loc = (loc + HISTORY_DEPTH_DEF - 1) % HISTORY_DEPTH_DEF;
            sum += int'(err_ring[loc]);
        end
        return sum >>> shift;
    endfunction

    function automatic t_res predict_target(input logic signed [SAMPLE_W-1:0] sample,
                                            input logic [PULSE_W-1:0] pulses,
                                            input logic [VCOUNT_W-1:0] vcount,
                                            input logic [POS_W-1:0] pos,
                                            input logic [POS_W-1:0] tgt,
                                            input logic restart);
        t_res r;
        int   filt;
        int   t;
        int   n;
        int   steps;
        int   moved;
        logic set;
        t = int'(regs.full_step_threshold);
        moved = 0;
        set = 1'b0;
        if (restart) fast_latch = 1'b0;
        err_ring[ring_wr] = sample;
        ring_wr = ring_wr + 4'd1;

        if (!fast_latch) begin
            filt = (pulses < 2) ? 0 : ring_average(2, 1);
        end else begin
            n = (pulses < regs.long_filter_pulse_limit) ? 4 : 8;
            if (pulses < n || vcount < n) filt = 0;
            else filt = ring_average(n, (n == 8) ? 3 : 2);
        end

        if (pulses >= regs.startup_pulse_limit) fast_latch = 1'b1;

        if (!fast_latch) begin
            if (filt > 9 * t) steps = 4;
            else if (filt > 6 * t) steps = 3;
            else if (filt > 3 * t) steps = 2;
            else if (filt > t) steps = 1;
            else if (filt > -t) steps = 0;
            else if (filt > -3 * t) steps = -1;
            else if (filt > -6 * t) steps = -2;
            else if (filt > -9 * t) steps = -3;
            else steps = -4;
            if (steps == 0 && pulses >= 4) fast_latch = 1'b1;
            moved = int'(pos) + steps * int'(regs.microstep_resolution);
            if (moved > 65535) moved = 65535;
            if (moved < 0) moved = 0;
            set = 1'b1;
        end else if (pos == tgt) begin
            if (filt > 10 * t) begin
                if (pos <= 16'hFFFE) begin
                    moved = int'(pos) + 1;
                    set = 1'b1;
                end
            end else if (filt < -int'(regs.slow_negative_threshold)) begin
                if (pos >= 1) begin
                    moved = int'(pos) - 1;
                    set = 1'b1;
                end
            end
        end

        r.new_target     = set ? 16'(moved) : '0;
        r.set_target     = set;
        r.filtered_error = 8'(filt);
        r.fast_done      = fast_latch;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            regs = CFG_RESET;
            for (int k = 0; k < HISTORY_DEPTH_DEF; k++) err_ring[k] = '0;
            ring_wr = '0;
            fast_latch = 1'b0;
            target_q.delete();
            o_errors = 0;
            o_results = 0;
            o_moves = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FULL_STEP:     regs.full_step_threshold     = i_cfg_data[3:0];
                    CFG_MICROSTEP:     regs.microstep_resolution    = i_cfg_data[8:0];
                    CFG_STARTUP_LIMIT: regs.startup_pulse_limit     = i_cfg_data;
                    CFG_LONG_LIMIT:    regs.long_filter_pulse_limit = i_cfg_data;
                    CFG_SLOW_NEG:      regs.slow_negative_threshold = i_cfg_data[6:0];
                    default: ;
                endcase
            end

            if (i_out_bus.valid && i_out_bus.ready) begin
                o_results++;
                if (target_q.size() == 0) begin
                    report_mismatch("unexpected result beat", 1, 0);
                end else begin
                    want = target_q.pop_front();
                    if (want.set_target) o_moves++;
                    if (i_out_bus.new_target !== want.new_target)
                        report_mismatch("new_target", i_out_bus.new_target, want.new_target);
                    if (i_out_bus.set_target !== want.set_target)
                        report_mismatch("set_target", i_out_bus.set_target, want.set_target);
                    if (i_out_bus.filtered_error !== want.filtered_error)
                        report_mismatch("filtered_error", i_out_bus.filtered_error,
                                        want.filtered_error);
                    if (i_out_bus.fast_done !== want.fast_done)
                        report_mismatch("fast_done", i_out_bus.fast_done, want.fast_done);
                end
            end

            if (i_in_bus.valid && i_in_bus.ready)
                target_q.push_back(predict_target(i_in_bus.error_sample, i_in_bus.pulse_count,
                                                  i_in_bus.valid_history_count,
                                                  i_in_bus.motor_position,
                                                  i_in_bus.motor_target,
                                                  i_in_bus.restart_fast));
        end
        o_pending = target_q.size();
    end

    final begin
        if (target_q.size() != 0)
            $display("%0d target results never arrived", target_q.size());
    end

endmodule

// ----- verif/tb_tuner_afc_step_controller.sv -----
`timescale 1ns / 1ps

module tb_tuner_afc_step_controller;
    import afc_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending_count;
    int                    result_count;
    int                    move_count;
    int                    beats_sent;
    int                    settings_used;
    bit                    calm;
    t_cfg                  phase_cfg [7];

    afc_in_if  in_bus ();
    afc_out_if out_bus ();

    tuner_afc_step_controller dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    afc_step_checker target_check (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_bus   (in_bus),
        .i_out_bus  (out_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (fail_count),
        .o_pending  (pending_count),
        .o_results  (result_count),
        .o_moves    (move_count)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk) begin
        if (!rst_n) out_bus.ready <= 1'b0;
        else out_bus.ready <= calm || ($urandom_range(99) >= 30);
    end

    initial begin
        #1_000_000;
        $display("timeout with %0d results outstanding", pending_count);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic t_cfg mk_cfg(input int t, input int res, input int start_lim,
                                    input int long_lim, input int neg);
        t_cfg c;
        c.full_step_threshold     = 4'(t);
        c.microstep_resolution    = 9'(res);
        c.startup_pulse_limit     = 16'(start_lim);
        c.long_filter_pulse_limit = 16'(long_lim);
        c.slow_negative_threshold = 7'(neg);
        return c;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input int value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= 16'(value);
        @(posedge clk);
    endtask

    task automatic load_config(input t_cfg c);
        write_reg(CFG_FULL_STEP, c.full_step_threshold);
        write_reg(CFG_MICROSTEP, c.microstep_resolution);
        write_reg(CFG_STARTUP_LIMIT, c.startup_pulse_limit);
        write_reg(CFG_LONG_LIMIT, c.long_filter_pulse_limit);
        write_reg(CFG_SLOW_NEG, c.slow_negative_threshold);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // hold until every result is back, then let the sequencer settle
    task automatic drain;
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic send_beat(input int sample, input int pulses, input int vcount,
                             input int pos, input int tgt, input int restart);
        while (!calm && $urandom_range(99) < 30) begin
            in_bus.valid <= 1'b0;
            @(posedge clk);
        end
        in_bus.valid               <= 1'b1;
        in_bus.error_sample        <= 8'(sample);
        in_bus.pulse_count         <= 16'(pulses);
        in_bus.valid_history_count <= 8'(vcount);
        in_bus.motor_position      <= 16'(pos);
        in_bus.motor_target        <= 16'(tgt);
        in_bus.restart_fast        <= 1'(restart);
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        beats_sent++;
    endtask

    // pulsing sessions: rising pulse count, decaying drift, mostly idle motor
    task automatic random_beats(input int count, input int jump, input bit pause_mid);
        int drift;
        int s;
        int pulses;
        int vcount;
        int sess_left;
        int pos;
        int tgt;
        int restart;
        sess_left = 0;
        pulses = 0;
        vcount = 0;
        drift = 0;
        for (int k = 0; k < count; k++) begin
            if (pause_mid && k == count / 2) drain;
            restart = 0;
            if (sess_left == 0) begin
                sess_left = $urandom_range(80, 15);
                pulses = $urandom_range(3, 0);
                vcount = 0;
                drift = int'($urandom_range(120)) - 60;
                restart = 1;
            end
            sess_left--;
            if ($urandom_range(99) < 12) begin
                send_beat($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                if ($urandom_range(9) == 0) pulses += $urandom_range(jump);
                else pulses++;
                if (pulses > 65535) pulses = 65535;
                if ($urandom_range(9) == 0) vcount = 0;
                else if (vcount < 255) vcount++;
                if ($urandom_range(3) == 0) drift = drift / 2;
                s = drift + int'($urandom_range(12)) - 6;
                case ($urandom_range(19))
                    0: s = -128;
                    1: s = 127;
                    default: ;
                endcase
                if (s > 127) s = 127;
                if (s < -128) s = -128;
                case ($urandom_range(9))
                    0: pos = $urandom_range(3);
                    1: pos = 65535 - $urandom_range(3);
                    default: pos = $urandom_range(65535);
                endcase
                if ($urandom_range(3) != 0) tgt = pos;
                else tgt = pos ^ (1 << $urandom_range(15));
                if ($urandom_range(29) == 0) restart = 1;
                send_beat(s, pulses, vcount, pos, tgt, restart);
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = CFG_FULL_STEP;
        cfg_data = '0;
        calm = 1'b0;
        beats_sent = 0;
        settings_used = 1;
        in_bus.valid = 1'b0;
        in_bus.error_sample = '0;
        in_bus.pulse_count = '0;
        in_bus.valid_history_count = '0;
        in_bus.motor_position = '0;
        in_bus.motor_target = '0;
        in_bus.restart_fast = 1'b0;
        phase_cfg[0] = mk_cfg(0, 256, 1, 1, 0);
        phase_cfg[1] = mk_cfg(12, 1, 65535, 65535, 127);
        phase_cfg[2] = mk_cfg(3, 16, 30, 60, 5);
        phase_cfg[3] = mk_cfg(15, 511, 12, 20, 100);
        phase_cfg[4] = mk_cfg(1, 0, 40, 100, 2);
        phase_cfg[5] = mk_cfg(7, 200, 100, 300, 64);
        phase_cfg[6] = CFG_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(127, 0, 0, 0, 0, 0);
        send_beat(127, 1, 0, 0, 0, 0);
        send_beat(127, 2, 0, 65535, 0, 0);
        send_beat(-128, 3, 0, 2, 0, 0);
        send_beat(-128, 3, 0, 0, 0, 0);
        send_beat(2, 3, 0, 1000, 0, 0);
        send_beat(2, 3, 0, 1000, 0, 0);
        send_beat(4, 3, 0, 1000, 0, 0);
        send_beat(4, 3, 0, 1000, 0, 0);
        send_beat(7, 3, 0, 1000, 0, 0);
        send_beat(7, 3, 0, 1000, 0, 0);
        send_beat(-2, 3, 0, 1000, 0, 0);
        send_beat(-2, 3, 0, 1000, 0, 0);
        send_beat(-8, 3, 0, 1000, 0, 0);
        send_beat(-8, 3, 0, 1000, 0, 0);
        send_beat(0, 10, 0, 1000, 0, 0);
        send_beat(0, 10, 0, 1000, 0, 0);
        send_beat(100, 10, 3, 500, 500, 0);
        send_beat(100, 10, 4, 65535, 65535, 0);
        send_beat(100, 10, 4, 500, 501, 0);
        send_beat(-128, 10, 4, 500, 500, 0);
        send_beat(-128, 10, 4, 0, 0, 0);
        send_beat(-128, 800, 8, 7, 7, 0);
        send_beat(5, 3, 255, 9, 9, 0);
        send_beat(60, 5, 0, 300, 300, 1);
        send_beat(60, 256, 0, 300, 300, 1);
        drain;

        for (int p = 0; p < 7; p++) begin
            load_config(phase_cfg[p]);
            calm = (p == 2);
            random_beats(118, int'(phase_cfg[p].long_filter_pulse_limit) + 10, p == 4);
            drain;
        end
        calm = 1'b0;

        $display("sent %0d beats across %0d register settings", beats_sent, settings_used);
        $display("checked %0d results, %0d of them target moves", result_count, move_count);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/afc_pkg.sv
hdl/afc_in_if.sv
hdl/afc_out_if.sv
hdl/afc_hist.sv
hdl/afc_decide.sv
hdl/tuner_afc_step_controller.sv
verif/afc_step_checker.sv
verif/tb_tuner_afc_step_controller.sv
